>>> rtl/assert_macros.svh
// assertion macros for the depth splat rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/pcds_pkg.sv
// types, constants and codes of the point cloud depth splat block
// no dependencies; used by the front, fifo, back and core rtl files of the block
package pcds_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int MAX_DIM    = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int QW         = $clog2(MAX_DIM);
    localparam int CNT_W      = $clog2(MAX_DIM + 1);
    localparam int PIX_COUNT  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W     = $clog2(PIX_COUNT);

    localparam int COORD_W    = 24;
    localparam int FOCAL_W    = 24;
    localparam int CENTER_W   = 18;
    localparam int IMG_W      = 11;
    localparam int RD_W       = 10;
    localparam int DEPTH_W    = 24;
    localparam int COLOR_W    = 8;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int DEN_W      = COORD_W + 7;
    localparam int LIM_W      = CNT_W + DEN_W;
    localparam int UN_W       = 50;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SQ_STEPS   = COORD_W;
    localparam int STEP_W     = $clog2(SQ_STEPS);
    localparam int CW         = (QW > RD_W) ? QW : RD_W;

    localparam int CLS_W      = 2;
    localparam int WORD_W     = CLS_W + DEPTH_W;

    // colour index: v = min(255, d*51/10000) by reciprocal multiply
    localparam int JET_SAT    = 50000;
    localparam int JET_K      = 5476083;
    localparam int JET_SHIFT  = 30;
    localparam int JET_DIV    = 10000;
    localparam int JET_MUL    = 51;
    localparam int DEP_LO_W   = 16;
    localparam int PROD_W     = 39;
    localparam int JET_W      = 22;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_OBST   = 2'd1,
        OP_GROUND = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [CLS_W-1:0] {
        CLS_EMPTY  = 2'd0,
        CLS_OBST   = 2'd1,
        CLS_GROUND = 2'd2
    } cls_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X    = 3'd0,
        CFG_FOCAL_Y    = 3'd1,
        CFG_CENTER_X   = 3'd2,
        CFG_CENTER_Y   = 3'd3,
        CFG_IMAGE_COLS = 3'd4,
        CFG_IMAGE_ROWS = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [FOCAL_W-1:0]  fx;
        logic [FOCAL_W-1:0]  fy;
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic [CNT_W-1:0]    cols;
        logic [CNT_W-1:0]    rows;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [CW-1:0]      col;
        logic [CW-1:0]      row;
        logic [DEPTH_W-1:0] range;
    } item_t;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_SUM, F_CHK, F_ITER, F_PUSH
    } fstate_t;

    typedef enum logic [2:0] {
        B_CLEAR, B_IDLE, B_SPRD, B_SPWR, B_RDADDR, B_RDMUL, B_RDDIV
    } bstate_t;

endpackage

>>> rtl/pcds_ram.sv
// generic single port ram with registered read data
// no dependencies
module pcds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/pcds_front.sv
// front end: accepts words, projects points, runs divide and square root
// depends on pcds_pkg; hands finished words to pcds_fifo
module pcds_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pcds_pkg::OP_W-1:0]      op,
    input  logic signed [pcds_pkg::COORD_W-1:0] point_x,
    input  logic signed [pcds_pkg::COORD_W-1:0] point_y,
    input  logic signed [pcds_pkg::COORD_W-1:0] point_z,
    input  logic [pcds_pkg::RD_W-1:0]      read_col,
    input  logic [pcds_pkg::RD_W-1:0]      read_row,
    input  pcds_pkg::cfg_t                 cfg,
    input  logic                           full,
    output logic                           busy,
    output logic                           push,
    output pcds_pkg::item_t                push_item
);
    import pcds_pkg::*;

    fstate_t state_reg, state_next;

    op_t                       op_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [RD_W-1:0]           rcol_reg, rrow_reg;
    logic signed [FOCAL_W+COORD_W:0]  fxy_reg, fyz_reg;
    logic signed [CENTER_W+COORD_W:0] cxx_reg, cyx_reg;
    logic [LIM_W-1:0]          limu_reg, limv_reg;
    logic [DEN_W-1:0]          den_reg;
    logic signed [SQ_W-1:0]    sqx_reg, sqy_reg, sqz_reg;
    logic signed [UN_W-1:0]    un_reg, vn_reg;
    logic [SQ_W-1:0]           ssum_reg;
    logic [LIM_W-1:0]          remu_reg, remv_reg, dsh_reg;
    logic [QW-1:0]             qu_reg, qv_reg;
    logic [SQ_W-1:0]           sqn_reg, sqres_reg, sqbit_reg;
    logic [STEP_W-1:0]         step_reg;

    logic keep;
    logic skip_point;
    logic ge_u, ge_v, sq_ge;
    logic [SQ_W-1:0] sq_trial;

    assign keep = !un_reg[UN_W-1] && (un_reg != '0)
               && (un_reg < $signed({{(UN_W-LIM_W){1'b0}}, limu_reg}))
               && !vn_reg[UN_W-1] && (vn_reg != '0)
               && (vn_reg < $signed({{(UN_W-LIM_W){1'b0}}, limv_reg}));
    assign skip_point = point_x[COORD_W-1] || (point_x == '0);
    assign ge_u     = remu_reg >= dsh_reg;
    assign ge_v     = remv_reg >= dsh_reg;
    assign sq_trial = sqres_reg + sqbit_reg;
    assign sq_ge    = sqn_reg >= sq_trial;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    if (op_t'(op) == OP_CLEAR || op_t'(op) == OP_READ)
                    begin
                        state_next = F_PUSH;
                    end
                    else if (!skip_point)
                    begin
                        state_next = F_MUL;
                    end
                end
            end
            F_MUL:  state_next = F_SUM;
            F_SUM:  state_next = F_CHK;
            F_CHK:  state_next = keep ? F_ITER : F_IDLE;
            F_ITER:
            begin
                if (step_reg == STEP_W'(SQ_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != F_IDLE);
        push = (state_reg == F_PUSH) && !full;
        push_item.op    = op_reg;
        push_item.range = sqres_reg[DEPTH_W-1:0];
        if (op_reg == OP_READ)
        begin
            push_item.col = CW'(rcol_reg);
            push_item.row = CW'(rrow_reg);
        end
        else
        begin
            push_item.col = CW'(qu_reg);
            push_item.row = CW'(qv_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    op_reg   <= op_t'(op);
                    px_reg   <= point_x;
                    py_reg   <= point_y;
                    pz_reg   <= point_z;
                    rcol_reg <= read_col;
                    rrow_reg <= read_row;
                end
            end
            F_MUL:
            begin
                fxy_reg  <= $signed({1'b0, cfg.fx}) * py_reg;
                fyz_reg  <= $signed({1'b0, cfg.fy}) * pz_reg;
                cxx_reg  <= $signed({1'b0, cfg.cx}) * px_reg;
                cyx_reg  <= $signed({1'b0, cfg.cy}) * px_reg;
                limu_reg <= LIM_W'(cfg.cols * px_reg[COORD_W-2:0]) << 8;
                limv_reg <= LIM_W'(cfg.rows * px_reg[COORD_W-2:0]) << 8;
                den_reg  <= {px_reg[COORD_W-2:0], 8'b0};
                sqx_reg  <= px_reg * px_reg;
                sqy_reg  <= py_reg * py_reg;
                sqz_reg  <= pz_reg * pz_reg;
            end
            F_SUM:
            begin
                // un = cx*x - fx*y, vn = cy*x - fy*z, all in 1/256 pixel units
                un_reg   <= UN_W'(cxx_reg) - UN_W'(fxy_reg);
                vn_reg   <= UN_W'(cyx_reg) - UN_W'(fyz_reg);
                ssum_reg <= $unsigned(sqx_reg) + $unsigned(sqy_reg) + $unsigned(sqz_reg);
            end
            F_CHK:
            begin
                remu_reg  <= un_reg[LIM_W-1:0];
                remv_reg  <= vn_reg[LIM_W-1:0];
                dsh_reg   <= LIM_W'(den_reg) << (QW - 1);
                qu_reg    <= '0;
                qv_reg    <= '0;
                sqn_reg   <= ssum_reg;
                sqres_reg <= '0;
                sqbit_reg <= SQ_W'(1) << (SQ_W - 2);
                step_reg  <= '0;
            end
            F_ITER:
            begin
                step_reg <= step_reg + 1'b1;
                // one root bit per cycle
                if (sq_ge)
                begin
                    sqn_reg   <= sqn_reg - sq_trial;
                    sqres_reg <= (sqres_reg >> 1) + sqbit_reg;
                end
                else
                begin
                    sqres_reg <= sqres_reg >> 1;
                end
                sqbit_reg <= sqbit_reg >> 2;
                // restoring divide, both axes share the shifted divisor
                if (step_reg < STEP_W'(QW))
                begin
                    if (ge_u)
                    begin
                        remu_reg <= remu_reg - dsh_reg;
                    end
                    if (ge_v)
                    begin
                        remv_reg <= remv_reg - dsh_reg;
                    end
                    qu_reg  <= {qu_reg[QW-2:0], ge_u};
                    qv_reg  <= {qv_reg[QW-2:0], ge_v};
                    dsh_reg <= dsh_reg >> 1;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

>>> rtl/pcds_fifo.sv
// two entry queue between front end and back end
// depends on pcds_pkg
module pcds_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pcds_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output pcds_pkg::item_t head,
    output logic            empty
);
    import pcds_pkg::*;

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

>>> rtl/pcds_back.sv
// back end: pixel store sweeps, 3x3 read-modify-write splats and pixel reads
// depends on pcds_pkg, pcds_ram and assert_macros.svh
`include "assert_macros.svh"
module pcds_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pcds_pkg::cfg_t                cfg,
    input  logic                          empty,
    input  pcds_pkg::item_t               head,
    output logic                          pop,
    output logic                          init_busy,
    output logic                          result_valid,
    output logic [pcds_pkg::COLOR_W-1:0]  blue,
    output logic [pcds_pkg::COLOR_W-1:0]  green,
    output logic [pcds_pkg::COLOR_W-1:0]  red,
    output logic                          pixel_filled,
    output logic [pcds_pkg::DEPTH_W-1:0]  pixel_depth
);
    import pcds_pkg::*;

    bstate_t state_reg, state_next;

    logic               init_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic [1:0]         di_reg, dj_reg;
    op_t                op_reg;
    logic [CW-1:0]      col_reg, row_reg;
    logic [DEPTH_W-1:0] range_reg;
    logic [ADDR_W-1:0]  cur_addr_reg;
    logic               inb_reg;
    logic               filled_reg;
    logic               big_reg;
    logic [DEPTH_W-1:0] dep_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               result_valid_reg;
    logic [COLOR_W-1:0] blue_reg, green_reg, red_reg;
    logic               pixel_filled_reg;
    logic [DEPTH_W-1:0] pixel_depth_reg;

    logic               ram_en, ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;

    logic [CW:0]        c_ext, r_ext;
    logic               nb_ok, last_nb, clr_last;
    logic [ADDR_W-1:0]  nb_addr, rd_addr;
    logic               rd_inb;
    cls_t               rd_cls, new_cls;
    logic [DEPTH_W-1:0] rd_dep;
    logic               upd;

    logic [7:0]         q0, vq, v;
    logic [JET_W-1:0]   d51, q0m, remv;
    logic [9:0]         four_v;
    logic [COLOR_W-1:0] b_c, g_c, r_c;

    pcds_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PIX_COUNT)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // neighbour offsets run 0..2, so c_ext and r_ext hold the neighbour col+1 and row+1
    assign c_ext    = {1'b0, col_reg} + (CW+1)'(di_reg);
    assign r_ext    = {1'b0, row_reg} + (CW+1)'(dj_reg);
    assign nb_ok    = (c_ext >= (CW+1)'(2)) && (c_ext <= (CW+1)'(cfg.cols))
                   && (r_ext >= (CW+1)'(2)) && (r_ext <= (CW+1)'(cfg.rows));
    assign nb_addr  = ADDR_W'((r_ext - 1'b1) * MAX_COLS + (c_ext - 1'b1));
    assign last_nb  = (di_reg == 2'd2) && (dj_reg == 2'd2);
    assign rd_inb   = (col_reg < MAX_COLS) && (row_reg < MAX_ROWS);
    assign rd_addr  = ADDR_W'(row_reg * MAX_COLS + col_reg);
    assign clr_last = (clr_cnt_reg == ADDR_W'(PIX_COUNT - 1));
    assign rd_cls   = cls_t'(ram_rdata[WORD_W-1:DEPTH_W]);
    assign rd_dep   = ram_rdata[DEPTH_W-1:0];

    // obstacle beats ground, same class keeps the nearer range
    always_comb
    begin
        upd     = 1'b0;
        new_cls = CLS_OBST;
        if (op_reg == OP_OBST)
        begin
            new_cls = CLS_OBST;
            upd     = (rd_cls != CLS_OBST) || (range_reg < rd_dep);
        end
        else
        begin
            new_cls = CLS_GROUND;
            if (rd_cls != CLS_OBST)
            begin
                upd = (rd_cls != CLS_GROUND) || (range_reg < rd_dep);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    case (head.op)
                        OP_CLEAR: state_next = B_CLEAR;
                        OP_READ:  state_next = B_RDADDR;
                        default:  state_next = B_SPRD;
                    endcase
                end
            end
            B_SPRD:
            begin
                if (nb_ok)
                begin
                    state_next = B_SPWR;
                end
                else if (last_nb)
                begin
                    state_next = B_IDLE;
                end
            end
            B_SPWR:   state_next = last_nb ? B_IDLE : B_SPRD;
            B_RDADDR: state_next = B_RDMUL;
            B_RDMUL:  state_next = B_RDDIV;
            B_RDDIV:  state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = '0;
        case (state_reg)
            B_CLEAR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = {CLS_EMPTY, {DEPTH_W{1'b0}}};
            end
            B_IDLE:
            begin
                pop = !empty;
            end
            B_SPRD:
            begin
                ram_en   = nb_ok;
                ram_addr = nb_addr;
            end
            B_SPWR:
            begin
                ram_en    = upd;
                ram_we    = upd;
                ram_addr  = cur_addr_reg;
                ram_wdata = {new_cls, range_reg};
            end
            B_RDADDR:
            begin
                ram_en   = rd_inb;
                ram_addr = rd_addr;
            end
            default:
            begin
            end
        endcase
    end

    // jet colour from the registered reciprocal product
    always_comb
    begin
        q0     = prod_reg[JET_SHIFT+7:JET_SHIFT];
        d51    = JET_W'(dep_reg[DEP_LO_W-1:0] * JET_MUL);
        q0m    = JET_W'(q0 * JET_DIV);
        remv   = d51 - q0m;
        vq     = (remv >= JET_W'(JET_DIV)) ? q0 + 8'd1 : q0;
        v      = big_reg ? 8'd255 : vq;
        four_v = {v, 2'b00};
        b_c    = '0;
        g_c    = '0;
        r_c    = '0;
        if (v inside {[8'd0:8'd63]})
        begin
            b_c = 8'd255;
            g_c = four_v[7:0];
        end
        else if (v inside {[8'd64:8'd127]})
        begin
            b_c = 8'((10'd510 - four_v));
            g_c = 8'd255;
        end
        else if (v inside {[8'd128:8'd191]})
        begin
            g_c = 8'd255;
            r_c = 8'((four_v - 10'd510));
        end
        else
        begin
            g_c = 8'((10'd1020 - four_v));
            r_c = 8'd255;
        end
        if (!filled_reg)
        begin
            b_c = '0;
            g_c = '0;
            r_c = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_CLEAR;
            init_reg         <= 1'b1;
            clr_cnt_reg      <= '0;
            di_reg           <= '0;
            dj_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == B_RDDIV);
            case (state_reg)
                B_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_last)
                    begin
                        init_reg <= 1'b0;
                    end
                end
                B_IDLE:
                begin
                    clr_cnt_reg <= '0;
                    di_reg      <= '0;
                    dj_reg      <= '0;
                end
                B_SPRD, B_SPWR:
                begin
                    if ((state_reg == B_SPWR) || !nb_ok)
                    begin
                        if (dj_reg == 2'd2)
                        begin
                            dj_reg <= '0;
                            di_reg <= di_reg + 1'b1;
                        end
                        else
                        begin
                            dj_reg <= dj_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    op_reg    <= head.op;
                    col_reg   <= head.col;
                    row_reg   <= head.row;
                    range_reg <= head.range;
                end
            end
            B_SPRD:
            begin
                cur_addr_reg <= nb_addr;
            end
            B_RDADDR:
            begin
                inb_reg <= rd_inb;
            end
            B_RDMUL:
            begin
                filled_reg <= inb_reg && (rd_cls == CLS_OBST || rd_cls == CLS_GROUND);
                dep_reg    <= (inb_reg && (rd_cls == CLS_OBST || rd_cls == CLS_GROUND))
                              ? rd_dep : '0;
                big_reg    <= (rd_dep >= DEPTH_W'(JET_SAT));
                prod_reg   <= PROD_W'(rd_dep[DEP_LO_W-1:0] * JET_K);
            end
            B_RDDIV:
            begin
                blue_reg         <= b_c;
                green_reg        <= g_c;
                red_reg          <= r_c;
                pixel_filled_reg <= filled_reg;
                pixel_depth_reg  <= dep_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign init_busy    = init_reg;
    assign result_valid = result_valid_reg;
    assign blue         = blue_reg;
    assign green        = green_reg;
    assign red          = red_reg;
    assign pixel_filled = pixel_filled_reg;
    assign pixel_depth  = pixel_depth_reg;

    `ASSERT_NXT(a_result_one_cycle, clk, rst_n, result_valid_reg, !result_valid_reg)
    `ASSERT_NXT(a_read_gives_result, clk, rst_n, state_reg == B_RDDIV, result_valid_reg)
    `ASSERT_IMP(a_write_states, clk, rst_n, ram_we, (state_reg == B_CLEAR) || (state_reg == B_SPWR))
    `ASSERT_IMP(a_empty_is_black, clk, rst_n, result_valid_reg && !pixel_filled_reg, (pixel_depth_reg == '0) && (blue_reg == '0) && (green_reg == '0) && (red_reg == '0))
endmodule

>>> rtl/point_cloud_depth_splat_core.sv
// Depth splat of lidar points into a min-range pixel store with jet colour readout.
// A word is taken when start is high and busy is low. A point that lands in the image
// keeps busy high through the setup states F_MUL, F_SUM and F_CHK, the square root
// iterations that also carry the 10 bit divides, and the hand-off state F_PUSH, which
// waits while the queue is full, so the front end takes no new word until it is done.
// Behind a two word queue the back end walks the 3x3 block on the single port pixel
// memory, with a read state and a write state for each pixel that lands and only the
// read state for each that misses. A read passes B_RDADDR, B_RDMUL and B_RDDIV after
// it leaves the queue and returns a one cycle result_valid strobe; the receiver
// cannot stall it. After reset, busy stays high while the class memory is swept to
// empty; a clear word runs the same sweep in the back end. cfg_ready is always high.
module point_cloud_depth_splat_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pcds_pkg::OP_W-1:0]          op,
    input  logic signed [pcds_pkg::COORD_W-1:0] point_x,
    input  logic signed [pcds_pkg::COORD_W-1:0] point_y,
    input  logic signed [pcds_pkg::COORD_W-1:0] point_z,
    input  logic [pcds_pkg::RD_W-1:0]          read_col,
    input  logic [pcds_pkg::RD_W-1:0]          read_row,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pcds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcds_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               result_valid,
    output logic [pcds_pkg::COLOR_W-1:0]       blue,
    output logic [pcds_pkg::COLOR_W-1:0]       green,
    output logic [pcds_pkg::COLOR_W-1:0]       red,
    output logic                               pixel_filled,
    output logic [pcds_pkg::DEPTH_W-1:0]       pixel_depth
);
    import pcds_pkg::*;

    logic [FOCAL_W-1:0]  focal_x_reg, focal_y_reg;
    logic [CENTER_W-1:0] center_x_reg, center_y_reg;
    logic [IMG_W-1:0]    image_cols_reg, image_rows_reg;
    cfg_t                cfg;

    logic  front_busy, init_busy;
    logic  push, full, pop, empty;
    item_t push_item, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg    <= FOCAL_W'(179200);
            focal_y_reg    <= FOCAL_W'(179200);
            center_x_reg   <= CENTER_W'(163840);
            center_y_reg   <= CENTER_W'(92160);
            image_cols_reg <= IMG_W'(1024);
            image_rows_reg <= IMG_W'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FOCAL_X:    focal_x_reg    <= cfg_data[FOCAL_W-1:0];
                CFG_FOCAL_Y:    focal_y_reg    <= cfg_data[FOCAL_W-1:0];
                CFG_CENTER_X:   center_x_reg   <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:   center_y_reg   <= cfg_data[CENTER_W-1:0];
                CFG_IMAGE_COLS: image_cols_reg <= cfg_data[IMG_W-1:0];
                CFG_IMAGE_ROWS: image_rows_reg <= cfg_data[IMG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // image size saturates at the store size
    always_comb
    begin
        cfg.fx   = focal_x_reg;
        cfg.fy   = focal_y_reg;
        cfg.cx   = center_x_reg;
        cfg.cy   = center_y_reg;
        cfg.cols = (32'(image_cols_reg) > MAX_COLS) ? CNT_W'(MAX_COLS) : CNT_W'(image_cols_reg);
        cfg.rows = (32'(image_rows_reg) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : CNT_W'(image_rows_reg);
    end

    assign busy = front_busy || init_busy;

    pcds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start && !init_busy),
        .op        (op),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .read_col  (read_col),
        .read_row  (read_row),
        .cfg       (cfg),
        .full      (full),
        .busy      (front_busy),
        .push      (push),
        .push_item (push_item)
    );

    pcds_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    pcds_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .init_busy    (init_busy),
        .result_valid (result_valid),
        .blue         (blue),
        .green        (green),
        .red          (red),
        .pixel_filled (pixel_filled),
        .pixel_depth  (pixel_depth)
    );
endmodule
